// ===== design/clsrng_pkg.sv =====
// Shared widths, generator constants and the value type for the combined generator.
package clsrng_pkg;

   localparam int VALUE_W = 31;
   localparam int MUL_W = 16;

   localparam int unsigned MOD_A = 32'd2147483563;
   localparam int unsigned MOD_B = 32'd2147483399;
   localparam int unsigned MUL_A = 32'd40014;
   localparam int unsigned MUL_B = 32'd40692;
   localparam int unsigned SPAN_A = MOD_A - 32'd1;
   localparam int unsigned SECOND_INIT = 32'd123456789;

   localparam int WARMUP = 8;
   localparam int TABLE_DEPTH_DEF = 32;

   typedef logic [VALUE_W-1:0] value_type;

endpackage

// ===== design/clsrng_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module clsrng_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== design/clsrng_modmul.sv =====
// Constant modular multiplier: registered product, then fold of the high part and one subtract.
module clsrng_modmul import clsrng_pkg::*; #(
   parameter int unsigned MULT = MUL_A,
   parameter int unsigned MODULUS = MOD_A
) (
   input  logic      clock,
   input  logic      start,
   input  value_type operand,
   output value_type result
);

   localparam int ProdW = VALUE_W + MUL_W;
   // 2^31 mod MODULUS, so hi * 2^31 folds to hi * Fold
   localparam longint unsigned Fold = (64'd1 << VALUE_W) - 64'(MODULUS);
   localparam int FoldW = $clog2(Fold + 64'd1);
   localparam int FpW = MUL_W + FoldW;

   logic [ProdW-1:0]   prod_ff;
   logic [ProdW-1:0]   prod_in;
   logic [FpW-1:0]     fold_prod;
   logic [VALUE_W:0]   sum;

   assign prod_in = ProdW'(operand) * ProdW'(MULT);

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= prod_in;
      end
   end

   // sum stays below twice the modulus, so one subtract settles it
   assign fold_prod = FpW'(prod_ff[ProdW-1:VALUE_W]) * FpW'(Fold);
   assign sum = (VALUE_W+1)'(prod_ff[VALUE_W-1:0]) + (VALUE_W+1)'(fold_prod);
   assign result = (sum >= (VALUE_W+1)'(MODULUS)) ?
                   VALUE_W'(sum - (VALUE_W+1)'(MODULUS)) : VALUE_W'(sum);

endmodule

// ===== design/clsrng_index.sv =====
// Table index from the previous output: reciprocal multiply, one correction, saturate.
module clsrng_index import clsrng_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           start,
   input  value_type                      last_value,
   output logic [$clog2(TABLE_DEPTH)-1:0] idx
);

   localparam int IdxW = $clog2(TABLE_DEPTH);
   localparam longint unsigned Bucket =
      64'd1 + (64'(MOD_A) - 64'd1) / 64'(TABLE_DEPTH);
   localparam longint unsigned Recip = (64'd1 << VALUE_W) / Bucket;
   localparam int RecipW = $clog2(Recip + 64'd1);
   localparam int QW = RecipW + 1;
   localparam int ProdW = VALUE_W + RecipW;
   localparam int BackW = VALUE_W + QW;

   logic [ProdW-1:0] prod_ff;
   value_type        value_ff;
   logic [IdxW-1:0]  idx_ff;
   logic [IdxW-1:0]  idx_in;
   logic [QW-1:0]    q_est;
   logic [QW-1:0]    q_fix;
   logic [BackW-1:0] back;
   value_type        rem;

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff  <= ProdW'(last_value) * ProdW'(Recip);
         value_ff <= last_value;
      end
      idx_ff <= idx_in;
   end

   // estimate is low by at most one
   always_comb begin
      q_est = QW'(prod_ff[ProdW-1:VALUE_W]);
      back = BackW'(q_est) * BackW'(Bucket);
      rem = value_ff - back[VALUE_W-1:0];
      q_fix = (rem >= VALUE_W'(Bucket)) ? q_est + QW'(1) : q_est;
      idx_in = (q_fix >= QW'(TABLE_DEPTH)) ? IdxW'(TABLE_DEPTH - 1) : q_fix[IdxW-1:0];
   end

   assign idx = idx_ff;

endmodule

// ===== design/combined_lcg_shuffle_rng.sv =====
// Top level: two congruential generators combined through a shuffle table held in RAM.
//
//   channel  direction  ports                          word
//   req      in         req_valid req_stall req_kind   draw (kind 0) or reseed+draw
//                       req_seed
//   rsp      out        rsp_valid rsp_stall rsp_value  one 31-bit value per request
//
// Draw sequence: from one acceptance to the next a draw passes through accept, multiply,
//   index, table read and table write, set by the registered shuffle-table read and the
//   registered product of the modular multiply. A reseed, or the first draw after reset,
//   adds a seed step and then the warm-up and table fill, each step a multiply and a store.
// Reset zeroes the first generator and the previous output and loads the second generator
//   with its start value; the table is not cleared, since the first draw always seeds and
//   fills it.
// A stalled response holds in its output register; the block only waits on rsp_stall when
//   a second result is ready before the first one has been taken.
module combined_lcg_shuffle_rng import clsrng_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [30:0] req_seed,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [30:0] rsp_value
);

   localparam int IdxW = $clog2(TABLE_DEPTH);
   localparam int CntW = $clog2(TABLE_DEPTH + WARMUP);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED,
      ST_WARM_MUL,
      ST_WARM_STORE,
      ST_DRAW_MUL,
      ST_DRAW_IDX,
      ST_FETCH,
      ST_DONE
   } state_type;

   state_type       state_ff, state_in;
   value_type       first_gen_ff, first_gen_in;
   value_type       second_gen_ff, second_gen_in;
   value_type       last_out_ff, last_out_in;
   value_type       seed_ff, seed_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            rsp_valid_ff, rsp_valid_in;
   value_type       rsp_value_ff, rsp_value_in;

   // datapath
   value_type        res_a, res_b;
   logic             start_a, start_b;
   logic [IdxW-1:0]  idx;
   logic             ram_wr_en;
   logic [IdxW-1:0]  ram_wr_addr;
   value_type        ram_wr_data;
   logic             ram_rd_en;
   value_type        ram_rd_data;
   value_type        seed_red;
   value_type        seed_fixed;
   logic [VALUE_W:0] diff;
   value_type        draw_value;
   logic             out_free;

   assign start_a = (state_ff == ST_WARM_MUL) || (state_ff == ST_DRAW_MUL);
   assign start_b = (state_ff == ST_DRAW_MUL);

   clsrng_modmul #(
      .MULT    (MUL_A),
      .MODULUS (MOD_A)
   ) u_mul_a (
      .clock   (clock),
      .start   (start_a),
      .operand (first_gen_ff),
      .result  (res_a)
   );

   clsrng_modmul #(
      .MULT    (MUL_B),
      .MODULUS (MOD_B)
   ) u_mul_b (
      .clock   (clock),
      .start   (start_b),
      .operand (second_gen_ff),
      .result  (res_b)
   );

   clsrng_index #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_index (
      .clock      (clock),
      .start      (start_b),
      .last_value (last_out_ff),
      .idx        (idx)
   );

   clsrng_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (idx),
      .rd_data (ram_rd_data)
   );

   // seed: wrap once into range, zero counts as one
   assign seed_red = (seed_ff >= VALUE_W'(MOD_A)) ? seed_ff - VALUE_W'(MOD_A) : seed_ff;
   assign seed_fixed = (seed_red == '0) ? VALUE_W'(1) : seed_red;

   // table entry minus second generator, lifted by the span when not positive
   assign diff = {1'b0, ram_rd_data} - {1'b0, second_gen_ff};
   assign draw_value = (diff[VALUE_W] || (diff == '0)) ?
                       VALUE_W'(diff + (VALUE_W+1)'(SPAN_A)) : VALUE_W'(diff);

   // output register can take a new word unless it holds one that is stalled
   assign out_free = !(rsp_valid_ff && rsp_stall);

   assign ram_rd_en = (state_ff == ST_FETCH);

   always_comb begin
      state_in      = state_ff;
      first_gen_in  = first_gen_ff;
      second_gen_in = second_gen_ff;
      last_out_in   = last_out_ff;
      seed_in       = seed_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = idx;
      ram_wr_data   = first_gen_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // seed on request, or when the first generator was never seeded
               if (req_kind || (first_gen_ff == '0)) begin
                  seed_in  = req_kind ? req_seed : VALUE_W'(1);
                  state_in = ST_SEED;
               end else begin
                  state_in = ST_DRAW_MUL;
               end
            end
         end
         ST_SEED: begin
            first_gen_in  = seed_fixed;
            second_gen_in = seed_fixed;
            cnt_in        = CntW'(TABLE_DEPTH + WARMUP - 1);
            state_in      = ST_WARM_MUL;
         end
         ST_WARM_MUL: begin
            state_in = ST_WARM_STORE;
         end
         ST_WARM_STORE: begin
            first_gen_in = res_a;
            // fill from the last entry down once warm-up is over
            if (cnt_ff < CntW'(TABLE_DEPTH)) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = cnt_ff[IdxW-1:0];
               ram_wr_data = res_a;
            end
            if (cnt_ff == '0) begin
               last_out_in = res_a;
               state_in    = ST_DRAW_MUL;
            end else begin
               cnt_in   = cnt_ff - CntW'(1);
               state_in = ST_WARM_MUL;
            end
         end
         ST_DRAW_MUL: begin
            state_in = ST_DRAW_IDX;
         end
         ST_DRAW_IDX: begin
            first_gen_in  = res_a;
            second_gen_in = res_b;
            state_in      = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free, then write back and emit
            if (out_free) begin
               ram_wr_en    = 1'b1;
               ram_wr_addr  = idx;
               ram_wr_data  = first_gen_ff;
               last_out_in  = draw_value;
               rsp_value_in = draw_value;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         first_gen_ff  <= '0;
         second_gen_ff <= VALUE_W'(SECOND_INIT);
         last_out_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         first_gen_ff  <= first_gen_in;
         second_gen_ff <= second_gen_in;
         last_out_ff   <= last_out_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      seed_ff      <= seed_in;
      cnt_ff       <= cnt_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

endmodule
